// ===== hw/rtl/btsc_pkg.sv =====
package btsc_pkg;

	localparam int DB_W       = 10;
	localparam int CNT_W      = 16;
	localparam int HOUR_W     = 5;
	localparam int VAL_W      = 6;
	localparam int MODE_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [VAL_W-1:0] HOUR_MAX   = 6'd23;
	localparam logic [VAL_W-1:0] MINUTE_MAX = 6'd59;
	localparam logic [CNT_W-1:0] CNT_MAX    = '1;

	localparam logic [DB_W-1:0]  DEBOUNCE_RST   = 10'd50;
	localparam logic [CNT_W-1:0] LONG_PRESS_RST = 16'd2000;
	localparam logic [CNT_W-1:0] TIMEOUT_RST    = 16'd20000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE   = 2'd0,
		CFG_LONG_PRESS = 2'd1,
		CFG_TIMEOUT    = 2'd2
	} cfg_idx_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_IDLE         = 3'd0,
		MODE_WAIT_RELEASE = 3'd1,
		MODE_WAIT_PRESS   = 3'd2,
		MODE_MEASURE      = 3'd3,
		MODE_EDIT_HOUR    = 3'd4,
		MODE_EDIT_MINUTE  = 3'd5
	} mode_t;

	typedef struct packed {
		logic [DB_W-1:0]  debounce_ticks;
		logic [CNT_W-1:0] long_press_ticks;
		logic [CNT_W-1:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic              down;
		logic              up;
		logic [HOUR_W-1:0] hour;
		logic [VAL_W-1:0]  minute;
	} tick_t;

	typedef struct packed {
		mode_t            mode;
		logic [VAL_W-1:0] value;
		logic             led;
		logic             wr_hour;
		logic             wr_minute;
	} result_t;

endpackage

// ===== hw/rtl/btsc_debounce.sv =====
module btsc_debounce (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic                      sample,
	input  logic [btsc_pkg::DB_W-1:0] debounce_ticks,
	output logic                      release_ev
);
	import btsc_pkg::*;

	logic            last_q;
	logic            settled_q;
	logic [DB_W-1:0] count_q;
	logic [DB_W-1:0] count_d;
	logic            settle;

	always_comb begin
		if (sample != last_q) begin
			count_d = '0;
		end else if (count_q < debounce_ticks) begin
			count_d = count_q + DB_W'(1);
		end else begin
			count_d = count_q;
		end
		settle     = (count_d >= debounce_ticks) && (sample != settled_q);
		release_ev = settle && sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= 1'b1;
			settled_q <= 1'b1;
			count_q   <= '0;
		end else if (step) begin
			last_q  <= sample;
			count_q <= count_d;
			if (settle) begin
				settled_q <= sample;
			end
		end
	end

endmodule

// ===== hw/rtl/btsc_menu.sv =====
module btsc_menu (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  btsc_pkg::tick_t   tick,
	input  logic              inc_ev,
	input  logic              dec_ev,
	input  btsc_pkg::cfg_t    cfg,
	output btsc_pkg::result_t result
);
	import btsc_pkg::*;

	mode_t            state_q;
	mode_t            state_d;
	logic [CNT_W-1:0] timeout_q;
	logic [CNT_W-1:0] timeout_d;
	logic [CNT_W-1:0] pulse_q;
	logic [CNT_W-1:0] pulse_d;
	logic [VAL_W-1:0] value_q;
	logic [VAL_W-1:0] value_d;
	logic             led_q;
	logic             led_d;
	logic             wr_hour;
	logic             wr_minute;

	logic [CNT_W-1:0] timeout_inc;
	logic [CNT_W-1:0] pulse_inc;
	logic             both_low;
	logic             timed_out;
	logic             long_press;
	logic [VAL_W-1:0] hour_clamp;
	logic [VAL_W-1:0] minute_clamp;
	logic [VAL_W-1:0] top;
	logic [VAL_W-1:0] value_up;
	logic [VAL_W-1:0] value_adj;

	always_comb begin
		timeout_inc  = (timeout_q == CNT_MAX) ? CNT_MAX : timeout_q + CNT_W'(1);
		pulse_inc    = (pulse_q == CNT_MAX) ? CNT_MAX : pulse_q + CNT_W'(1);
		both_low     = !tick.down && !tick.up;
		timed_out    = timeout_inc >= cfg.timeout_ticks;
		long_press   = pulse_q > cfg.long_press_ticks;
		hour_clamp   = ({1'b0, tick.hour} > HOUR_MAX) ? HOUR_MAX : {1'b0, tick.hour};
		minute_clamp = (tick.minute > MINUTE_MAX) ? MINUTE_MAX : tick.minute;
		top          = (state_q == MODE_EDIT_HOUR) ? HOUR_MAX : MINUTE_MAX;
		// up applies first, then down, both saturating
		if (inc_ev) begin
			value_up = (value_q >= top) ? top : value_q + VAL_W'(1);
		end else begin
			value_up = value_q;
		end
		value_adj = (dec_ev && value_up != '0) ? value_up - VAL_W'(1) : value_up;
	end

	// next state
	always_comb begin
		unique case (state_q)
			MODE_WAIT_RELEASE: begin
				if (timed_out) state_d = MODE_IDLE;
				else if (tick.down) state_d = MODE_WAIT_PRESS;
				else state_d = MODE_WAIT_RELEASE;
			end
			MODE_WAIT_PRESS: begin
				if (timed_out) state_d = MODE_IDLE;
				else if (!tick.down) state_d = MODE_MEASURE;
				else state_d = MODE_WAIT_PRESS;
			end
			MODE_MEASURE: begin
				if (tick.down) state_d = long_press ? MODE_EDIT_HOUR : MODE_EDIT_MINUTE;
				else if (timed_out) state_d = MODE_IDLE;
				else state_d = MODE_MEASURE;
			end
			MODE_EDIT_HOUR, MODE_EDIT_MINUTE: begin
				state_d = both_low ? MODE_IDLE : state_q;
			end
			default: begin
				state_d = both_low ? MODE_WAIT_RELEASE : MODE_IDLE;
			end
		endcase
	end

	// counters, value and strobes
	always_comb begin
		timeout_d = timeout_q;
		pulse_d   = pulse_q;
		value_d   = value_q;
		led_d     = led_q;
		wr_hour   = 1'b0;
		wr_minute = 1'b0;
		unique case (state_q)
			MODE_WAIT_RELEASE: begin
				timeout_d = timeout_inc;
			end
			MODE_WAIT_PRESS: begin
				timeout_d = timeout_inc;
				if (!tick.down) pulse_d = CNT_W'(1);
			end
			MODE_MEASURE: begin
				timeout_d = timeout_inc;
				if (!tick.down) pulse_d = pulse_inc;
				else value_d = long_press ? hour_clamp : minute_clamp;
			end
			MODE_EDIT_HOUR: begin
				value_d = value_adj;
				wr_hour = both_low;
			end
			MODE_EDIT_MINUTE: begin
				value_d   = value_adj;
				wr_minute = both_low;
			end
			default: begin
				if (both_low) begin
					led_d     = 1'b1;
					timeout_d = '0;
					pulse_d   = '0;
				end
			end
		endcase
		result.mode      = state_d;
		result.value     = value_d;
		result.led       = led_d;
		result.wr_hour   = wr_hour;
		result.wr_minute = wr_minute;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= MODE_IDLE;
			timeout_q <= '0;
			pulse_q   <= '0;
			value_q   <= '0;
			led_q     <= 1'b0;
		end else if (step) begin
			state_q   <= state_d;
			timeout_q <= timeout_d;
			pulse_q   <= pulse_d;
			value_q   <= value_d;
			led_q     <= led_d;
		end
	end

	a_strobe_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_hour && wr_minute))
		else $error("both write strobes raised");

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_hour || wr_minute) |-> state_d == MODE_IDLE)
		else $error("write strobe without leaving edit");

	a_led_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		led_q |=> led_q)
		else $error("led dropped");

	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == MODE_EDIT_HOUR |-> value_q <= HOUR_MAX)
		else $error("hour edit value out of range");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		value_q <= MINUTE_MAX)
		else $error("edit value out of range");

endmodule

// ===== hw/rtl/button_time_set_controller_unit.sv =====
// Two-button time setter, advanced by one word per 1 ms tick.
// Input channel (in_valid / in_stall): each word carries the raw active-low
// down_level and up_level pins and the current clock_hour / clock_minute.
// Output channel (out_valid / out_stall): exactly one result word per input
// word, in order: mode, edit_value, led_on and the one-tick write_hour /
// write_minute strobes (a strobe means: store edit_value into the clock).
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
// always high; index 0 debounce ticks (low 10 bits), 1 long-press ticks,
// 2 timeout ticks. Write only while no word is in flight.
// Path: an accepted word goes through the input register, then the result
// register, which raises out_valid.
// Throughput: one word per cycle while a stalled result does not hold it up;
// the menu state and both debouncers update in the single cycle a word moves
// from the input register to the result register.
// Stall: a stalled result holds; the input register still takes one word
// behind it, after that in_stall rises in the same cycle as out_stall.
// Reset: menu idle, LED off, value 0, debouncers released, config registers
// at 50 / 2000 / 20000, both channels empty.
module button_time_set_controller_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            down_level,
	input  logic                            up_level,
	input  logic [btsc_pkg::HOUR_W-1:0]     clock_hour,
	input  logic [btsc_pkg::VAL_W-1:0]      clock_minute,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [btsc_pkg::MODE_W-1:0]     mode,
	output logic [btsc_pkg::VAL_W-1:0]      edit_value,
	output logic                            led_on,
	output logic                            write_hour,
	output logic                            write_minute,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [btsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [btsc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import btsc_pkg::*;

	cfg_t    cfg_q;
	tick_t   tick_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	result_t result;
	logic    out_free;
	logic    advance;
	logic    in_acc;
	logic    inc_ev;
	logic    dec_ev;

	assign out_free  = !valid_s2 || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks   <= DEBOUNCE_RST;
			cfg_q.long_press_ticks <= LONG_PRESS_RST;
			cfg_q.timeout_ticks    <= TIMEOUT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DEBOUNCE:   cfg_q.debounce_ticks   <= cfg_data[DB_W-1:0];
				CFG_LONG_PRESS: cfg_q.long_press_ticks <= cfg_data[CNT_W-1:0];
				CFG_TIMEOUT:    cfg_q.timeout_ticks    <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			tick_s1.down   <= down_level;
			tick_s1.up     <= up_level;
			tick_s1.hour   <= clock_hour;
			tick_s1.minute <= clock_minute;
		end
	end

	btsc_debounce u_db_down (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.sample         (tick_s1.down),
		.debounce_ticks (cfg_q.debounce_ticks),
		.release_ev     (dec_ev)
	);

	btsc_debounce u_db_up (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.sample         (tick_s1.up),
		.debounce_ticks (cfg_q.debounce_ticks),
		.release_ev     (inc_ev)
	);

	btsc_menu u_menu (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.tick   (tick_s1),
		.inc_ev (inc_ev),
		.dec_ev (dec_ev),
		.cfg    (cfg_q),
		.result (result)
	);

	// result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign out_valid    = valid_s2;
	assign mode         = res_s2.mode;
	assign edit_value   = res_s2.value;
	assign led_on       = res_s2.led;
	assign write_hour   = res_s2.wr_hour;
	assign write_minute = res_s2.wr_minute;

endmodule

// ===== sim/tb_button_time_set_controller_unit.sv =====
`timescale 1ns / 1ps

module tb_button_time_set_controller_unit;
	import btsc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	logic down_level = 1'b1;
	logic up_level = 1'b1;
	logic [HOUR_W-1:0] clock_hour = '0;
	logic [VAL_W-1:0] clock_minute = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [MODE_W-1:0] mode;
	logic [VAL_W-1:0] edit_value;
	logic led_on;
	logic write_hour;
	logic write_minute;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	button_time_set_controller_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.down_level(down_level),
		.up_level(up_level),
		.clock_hour(clock_hour),
		.clock_minute(clock_minute),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mode(mode),
		.edit_value(edit_value),
		.led_on(led_on),
		.write_hour(write_hour),
		.write_minute(write_minute),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// shadow copy of the setter: config, menu and both debouncers
	logic [DB_W-1:0] cfg_db = DEBOUNCE_RST;
	logic [CNT_W-1:0] cfg_lp = LONG_PRESS_RST;
	logic [CNT_W-1:0] cfg_to = TIMEOUT_RST;
	mode_t ms_mode = MODE_IDLE;
	logic [CNT_W-1:0] ms_timeout = '0;
	logic [CNT_W-1:0] ms_pulse = '0;
	logic [VAL_W-1:0] ms_value = '0;
	logic ms_led = 1'b0;
	logic [DB_W-1:0] db_count [2] = '{'0, '0};
	logic db_last [2] = '{1'b1, 1'b1};
	logic db_settled [2] = '{1'b1, 1'b1};

	result_t expected_words [$];
	result_t want;
	int n_err = 0;
	int n_sent = 0;
	int burst_left = 0;
	int gap_max = 0;
	int stall_style = 0;
	int hold_req = 0;
	int hold_left = 0;
	int stall_cyc = 0;

	// returns 1 when button b settles to released on this tick
	function automatic logic settle_button(input int b, input logic s);
		if (s != db_last[b]) begin
			db_last[b] = s;
			db_count[b] = '0;
		end else if (db_count[b] < cfg_db) begin
			db_count[b] = db_count[b] + 1'b1;
		end
		if (db_count[b] >= cfg_db && s != db_settled[b]) begin
			db_settled[b] = s;
			return s;
		end
		return 1'b0;
	endfunction

	function automatic result_t advance_setter(input logic dn, input logic up,
			input logic [HOUR_W-1:0] hr, input logic [VAL_W-1:0] mn);
		result_t r;
		logic dec;
		logic inc;
		logic both_low;
		logic [VAL_W-1:0] top;
		dec = settle_button(0, dn);
		inc = settle_button(1, up);
		both_low = !dn && !up;
		r.wr_hour = 1'b0;
		r.wr_minute = 1'b0;
		case (ms_mode)
			MODE_WAIT_RELEASE, MODE_WAIT_PRESS, MODE_MEASURE: begin
				if (ms_timeout != CNT_MAX)
					ms_timeout = ms_timeout + 1'b1;
				if (ms_mode == MODE_WAIT_RELEASE) begin
					if (dn)
						ms_mode = MODE_WAIT_PRESS;
				end else if (ms_mode == MODE_WAIT_PRESS) begin
					if (!dn) begin
						ms_mode = MODE_MEASURE;
						ms_pulse = 1;
					end
				end else if (!dn) begin
					if (ms_pulse != CNT_MAX)
						ms_pulse = ms_pulse + 1'b1;
				end else if (ms_pulse > cfg_lp) begin
					ms_mode = MODE_EDIT_HOUR;
					ms_value = (hr > HOUR_MAX) ? HOUR_MAX : VAL_W'(hr);
				end else begin
					ms_mode = MODE_EDIT_MINUTE;
					ms_value = (mn > MINUTE_MAX) ? MINUTE_MAX : mn;
				end
				if (ms_mode != MODE_EDIT_HOUR && ms_mode != MODE_EDIT_MINUTE
						&& ms_timeout >= cfg_to)
					ms_mode = MODE_IDLE;
			end
			MODE_EDIT_HOUR, MODE_EDIT_MINUTE: begin
				top = (ms_mode == MODE_EDIT_HOUR) ? HOUR_MAX : MINUTE_MAX;
				if (inc)
					ms_value = (ms_value >= top) ? top : ms_value + 1'b1;
				if (dec && ms_value != 0)
					ms_value = ms_value - 1'b1;
				if (both_low) begin
					if (ms_mode == MODE_EDIT_HOUR)
						r.wr_hour = 1'b1;
					else
						r.wr_minute = 1'b1;
					ms_mode = MODE_IDLE;
				end
			end
			default: begin
				ms_mode = MODE_IDLE;
				if (both_low) begin
					ms_led = 1'b1;
					ms_timeout = '0;
					ms_pulse = '0;
					ms_mode = MODE_WAIT_RELEASE;
				end
			end
		endcase
		r.mode = ms_mode;
		r.value = ms_value;
		r.led = ms_led;
		return r;
	endfunction

	function automatic logic rbit();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic logic [HOUR_W-1:0] rand_hour();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return HOUR_W'(HOUR_MAX);
			2: return '1;
			default: return HOUR_W'($urandom_range(0, 31));
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] rand_min();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return MINUTE_MAX;
			2: return '1;
			default: return VAL_W'($urandom_range(0, 63));
		endcase
	endfunction

	// offer one tick word, hold it until taken, then predict its result
	task automatic send_tick(input logic dn, input logic up,
			input logic [HOUR_W-1:0] hr, input logic [VAL_W-1:0] mn);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		down_level <= dn;
		up_level <= up;
		clock_hour <= hr;
		clock_minute <= mn;
		do @(posedge clk); while (in_stall);
		expected_words.push_back(advance_setter(dn, up, hr, mn));
		n_sent++;
	endtask

	// drop valid and wait for every expected word to come out
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] db,
			input logic [CFG_DATA_W-1:0] lp, input logic [CFG_DATA_W-1:0] to);
		logic [CFG_DATA_W-1:0] vals [3];
		cfg_idx_t idxs [3];
		vals = '{db, lp, to};
		idxs = '{CFG_DEBOUNCE, CFG_LONG_PRESS, CFG_TIMEOUT};
		drain();
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idxs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			case (idxs[i])
				CFG_DEBOUNCE: cfg_db = vals[i][DB_W-1:0];
				CFG_LONG_PRESS: cfg_lp = vals[i];
				CFG_TIMEOUT: cfg_to = vals[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// enter the menu, measure one pulse, then edit and, in most runs, leave
	task automatic run_menu();
		int plen;
		int pcap;
		int dcap;
		logic which;
		pcap = (cfg_lp < 12) ? int'(cfg_lp) + 3 : 12;
		dcap = (cfg_db + 2 > 8) ? 8 : int'(cfg_db) + 2;
		send_tick(1'b0, 1'b0, rand_hour(), rand_min());
		repeat ($urandom_range(0, 2)) send_tick(1'b0, rbit(), rand_hour(), rand_min());
		repeat ($urandom_range(1, 3)) send_tick(1'b1, rbit(), rand_hour(), rand_min());
		plen = $urandom_range(1, pcap);
		repeat (plen) send_tick(1'b0, rbit(), rand_hour(), rand_min());
		send_tick(1'b1, rbit(), rand_hour(), rand_min());
		repeat ($urandom_range(0, 6)) begin
			which = rbit();
			repeat ($urandom_range(0, dcap))
				send_tick(which, !which, rand_hour(), rand_min());
			repeat ($urandom_range(0, dcap))
				send_tick(1'b1, 1'b1, rand_hour(), rand_min());
		end
		if ($urandom_range(0, 4) != 0)
			send_tick(1'b0, 1'b0, rand_hour(), rand_min());
	endtask

	task automatic test_reset_config();
		send_tick(1'b1, 1'b1, '0, '0);
		send_tick(1'b0, 1'b1, '1, '1);
		send_tick(1'b1, 1'b0, HOUR_W'(HOUR_MAX), MINUTE_MAX);
		send_tick(1'b0, 1'b0, 5'd7, 6'd30);
		send_tick(1'b1, 1'b1, 5'd7, 6'd30);
		send_tick(1'b0, 1'b1, 5'd7, 6'd30);
		// short pulse under the reset long-press length: minute edit, clamped load
		send_tick(1'b1, 1'b1, 5'd5, '1);
		send_tick(1'b0, 1'b0, 5'd5, 6'd12);
	endtask

	task automatic test_hour_edit();
		set_config(16'd1, 16'd3, CNT_MAX);
		send_tick(1'b0, 1'b0, 5'd3, 6'd4);
		send_tick(1'b1, 1'b1, 5'd3, 6'd4);
		repeat (5) send_tick(1'b0, 1'b1, 5'd3, 6'd4);
		send_tick(1'b1, 1'b1, '1, 6'd0);
		send_tick(1'b1, 1'b0, '0, '0);
		repeat (2) send_tick(1'b1, 1'b1, '0, '0);
		send_tick(1'b0, 1'b1, '0, '0);
		repeat (2) send_tick(1'b1, 1'b1, '0, '0);
		send_tick(1'b0, 1'b0, '0, '0);
	endtask

	task automatic test_zero_timeout();
		set_config(16'd0, 16'd0, 16'd0);
		send_tick(1'b0, 1'b0, 5'd1, 6'd1);
		send_tick(1'b1, 1'b1, 5'd1, 6'd1);
		send_tick(1'b0, 1'b0, 5'd1, 6'd1);
		send_tick(1'b0, 1'b0, 5'd1, 6'd1);
	endtask

	task automatic test_backpressure();
		set_config(16'd2, 16'd4, 16'd40);
		stall_style = 0;
		gap_max = 0;
		hold_req = 200;
		repeat (3) run_menu();
		drain();
		stall_style = 2;
		gap_max = 4;
		repeat (2) run_menu();
		drain();
	endtask

	task automatic test_random_menus();
		logic [CFG_DATA_W-1:0] db;
		logic [CFG_DATA_W-1:0] lp;
		logic [CFG_DATA_W-1:0] to;
		while (n_sent < 1850) begin
			case ($urandom_range(0, 9))
				0: begin
					db = {6'($urandom), 10'h3ff};
					lp = CNT_MAX;
					to = CNT_MAX;
				end
				1: begin
					db = CFG_DATA_W'($urandom_range(0, 1));
					lp = CFG_DATA_W'($urandom_range(0, 1));
					to = CFG_DATA_W'($urandom_range(0, 1));
				end
				default: begin
					db = {6'($urandom), 10'($urandom_range(0, 5))};
					lp = CFG_DATA_W'($urandom_range(0, 10));
					to = ($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom_range(2, 30))
						: CNT_MAX;
				end
			endcase
			set_config(db, lp, to);
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			stall_style = $urandom_range(0, 3);
			if ($urandom_range(0, 5) == 0)
				hold_req = $urandom_range(20, 120);
			repeat ($urandom_range(2, 5)) begin
				run_menu();
				repeat ($urandom_range(0, 5))
					send_tick(rbit(), rbit(), rand_hour(), rand_min());
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_hour_edit();
		test_zero_timeout();
		test_backpressure();
		test_random_menus();
		drain();
		repeat (8) @(posedge clk);
		if (n_err == 0 && expected_words.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	// receiver: a long hold on request, otherwise the stall pattern of the phase
	always @(posedge clk) begin
		stall_cyc = stall_cyc + 1;
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			case (stall_style)
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				3: out_stall <= ((stall_cyc % 7) < 3);
				default: out_stall <= 1'b0;
			endcase
		end
	end

	task automatic check_field(input string name, input logic [7:0] expv,
			input logic [7:0] actv);
		if (actv !== expv) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, expv, actv);
			n_err++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$display("%0t: result word with none expected, mode actual %0d",
					$time, mode);
				n_err++;
			end else begin
				want = expected_words.pop_front();
				check_field("mode", 8'(want.mode), 8'(mode));
				check_field("edit_value", 8'(want.value), 8'(edit_value));
				check_field("led_on", 8'(want.led), 8'(led_on));
				check_field("write_hour", 8'(want.wr_hour), 8'(write_hour));
				check_field("write_minute", 8'(want.wr_minute), 8'(write_minute));
			end
		end
	end

endmodule

// ===== filelist.f =====
hw/rtl/btsc_pkg.sv
hw/rtl/btsc_debounce.sv
hw/rtl/btsc_menu.sv
hw/rtl/button_time_set_controller_unit.sv
sim/tb_button_time_set_controller_unit.sv
